// File: rtl/ksa_pkg.sv
`timescale 1ns / 1ps

package ksa_pkg;

	// table geometry; slot 0 is never handed out
	localparam int SLOTS  = 4096;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [4:0] KEY_LEN_FULL = 5'd16;

	// commands
	localparam logic [2:0] CMD_WRITE       = 3'd0;
	localparam logic [2:0] CMD_COMPARE     = 3'd1;
	localparam logic [2:0] CMD_GET         = 3'd2;
	localparam logic [2:0] CMD_DELETE      = 3'd3;
	localparam logic [2:0] CMD_SET_CONTENT = 3'd4;
	localparam logic [2:0] CMD_GET_CONTENT = 3'd5;

	// result status codes
	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_BAD_KEY     = 3'd1;
	localparam logic [2:0] STS_FULL        = 3'd2;
	localparam logic [2:0] STS_BAD_BLOCK   = 3'd3;
	localparam logic [2:0] STS_BAD_CONTENT = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ksa_state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  block_file;
		logic [31:0] block_index;
		logic [4:0]  key_len;
		logic [63:0] key_suffix_hi;
		logic [39:0] key_suffix_lo;
		logic [15:0] content_file;
		logic [31:0] content_data_id;
		logic [31:0] content_data_len;
	} ksa_in_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              matched;
		logic [7:0]        out_file;
		logic [SLOT_W-1:0] out_index;
		logic [63:0]       suffix_hi;
		logic [39:0]       suffix_lo;
		logic [7:0]        out_content_file;
		logic [31:0]       out_content_data_id;
		logic [31:0]       out_content_data_len;
		logic [SLOT_W-1:0] used_count;
	} ksa_out_t;

	// one table entry: key suffix and content id
	typedef struct packed {
		logic [63:0] suffix_hi;
		logic [39:0] suffix_lo;
		logic [7:0]  content_file;
		logic [31:0] data_id;
		logic [31:0] cid_len;
	} ksa_entry_t;

endpackage

// File: rtl/key_slot_table_allocator_top.sv
`timescale 1ns / 1ps

// Slot table for hashed 16-byte keys with a free-list allocator. A command is
// taken when start is high and busy is low; its single result appears on rsp
// for exactly one cycle with done high, and the receiver cannot stall it, so
// capture rsp whenever done is high. Each command keeps the block busy for one
// cycle after it is taken, so a new command is not taken until the
// read-modify-write of the entry and link memories is done (read in the cycle
// the command is taken, written back in the next). The result of one command
// is on rsp during the cycle in which the next command may be taken. Writes of
// own_file_id are accepted at any time (cfg_ready is always high) but must only
// be issued while no command is outstanding. No clearing pass runs after reset:
// slots above the high-water count are never read, and a fresh slot is written
// in full when it is first handed out, so stale memory contents never reach rsp.
module key_slot_table_allocator_top
	import ksa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  ksa_in_t    req,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       done,
	output ksa_out_t   rsp
);

	// entry and link memories
	ksa_entry_t        entry_mem [SLOTS];
	logic [SLOT_W-1:0] link_mem  [SLOTS];

	ksa_state_t        state_q, state_d;
	logic [7:0]        own_file_q;
	logic [SLOT_W-1:0] hw_q, hw_d;
	logic [SLOT_W-1:0] free_head_q, free_head_d;

	// stage 1: command captured at the transfer, read data arrives alongside
	ksa_in_t           req_s1;
	logic              bid_ok_s1;
	logic              pop_ok_s1;
	ksa_entry_t        entry_rd_q;
	logic [SLOT_W-1:0] link_rd_q;

	logic              accept;
	logic [SLOT_W-1:0] rd_addr;
	logic              bid_ok;
	logic              pop_ok;

	logic              ent_we;
	logic [SLOT_W-1:0] ent_waddr;
	ksa_entry_t        ent_wdata;
	logic              lnk_we;
	logic [SLOT_W-1:0] lnk_waddr;
	logic [SLOT_W-1:0] lnk_wdata;

	ksa_out_t          rsp_d;
	ksa_out_t          rsp_q;
	logic              done_q;

	assign busy      = (state_q == ST_EXEC);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// block id check, done at the transfer; high_water and own id hold until exec
	assign bid_ok = (req.block_file == own_file_q)
		&& (req.block_index != 32'd0)
		&& (req.block_index < 32'(SLOTS))
		&& (req.block_index <= 32'(hw_q));

	// pop only a head that points at a slot already handed out
	assign pop_ok = (free_head_q != '0) && (free_head_q <= hw_q);

	// a write reads the entry at the list head; all other commands at the block id
	assign rd_addr = (req.cmd == CMD_WRITE) ? free_head_q : req.block_index[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			own_file_q  <= '0;
			hw_q        <= '0;
			free_head_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			hw_q        <= hw_d;
			free_head_q <= free_head_d;
			done_q      <= (state_q == ST_EXEC);
			if (cfg_valid && cfg_ready) begin
				own_file_q <= cfg_data;
			end
		end
	end

	// capture command and precomputed checks at the transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= req;
			bid_ok_s1 <= bid_ok;
			pop_ok_s1 <= pop_ok;
		end
		if (state_q == ST_EXEC) begin
			rsp_q <= rsp_d;
		end
	end

	// memory read ports, registered
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_rd_q <= entry_mem[rd_addr];
			link_rd_q  <= link_mem[free_head_q];
		end
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_waddr] <= ent_wdata;
		end
		if (lnk_we) begin
			link_mem[lnk_waddr] <= lnk_wdata;
		end
	end

	// next state, memory write-back and result
	always_comb begin
		logic [SLOT_W-1:0] slot;
		logic              content_bad;

		state_d     = state_q;
		hw_d        = hw_q;
		free_head_d = free_head_q;
		ent_we      = 1'b0;
		ent_waddr   = req_s1.block_index[SLOT_W-1:0];
		ent_wdata   = entry_rd_q;
		lnk_we      = 1'b0;
		lnk_waddr   = req_s1.block_index[SLOT_W-1:0];
		lnk_wdata   = '0;
		rsp_d       = '0;
		slot        = req_s1.block_index[SLOT_W-1:0];
		content_bad = (req_s1.content_file[15:8] != 8'd0)
			|| (req_s1.content_data_id == 32'd0)
			|| (req_s1.content_data_len == 32'd0);

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				case (req_s1.cmd)
					CMD_WRITE: begin
						if (req_s1.key_len != KEY_LEN_FULL) begin
							rsp_d.status = STS_BAD_KEY;
						end else if (pop_ok_s1) begin
							// pop the head, keep the slot's content id
							slot        = free_head_q;
							free_head_d = (link_rd_q > hw_q) ? '0 : link_rd_q;
							lnk_we      = 1'b1;
							lnk_waddr   = slot;
							lnk_wdata   = '0;
							ent_we      = 1'b1;
							ent_waddr   = slot;
							ent_wdata.suffix_hi = req_s1.key_suffix_hi;
							ent_wdata.suffix_lo = req_s1.key_suffix_lo;
							rsp_d.out_file  = own_file_q;
							rsp_d.out_index = slot;
						end else if (hw_q < SLOT_W'(SLOTS - 1)) begin
							// bump: first use of this slot, write the whole entry
							slot      = hw_q + 1'b1;
							hw_d      = slot;
							ent_we    = 1'b1;
							ent_waddr = slot;
							ent_wdata = '0;
							ent_wdata.suffix_hi = req_s1.key_suffix_hi;
							ent_wdata.suffix_lo = req_s1.key_suffix_lo;
							rsp_d.out_file  = own_file_q;
							rsp_d.out_index = slot;
						end else begin
							rsp_d.status = STS_FULL;
						end
					end
					CMD_COMPARE, CMD_GET, CMD_DELETE, CMD_SET_CONTENT, CMD_GET_CONTENT: begin
						if (!bid_ok_s1) begin
							rsp_d.status = STS_BAD_BLOCK;
						end else begin
							case (req_s1.cmd)
								CMD_COMPARE: begin
									rsp_d.matched = (entry_rd_q.suffix_hi == req_s1.key_suffix_hi)
										&& (entry_rd_q.suffix_lo == req_s1.key_suffix_lo);
								end
								CMD_GET: begin
									rsp_d.suffix_hi = entry_rd_q.suffix_hi;
									rsp_d.suffix_lo = entry_rd_q.suffix_lo;
								end
								CMD_DELETE: begin
									// clear the entry and push the slot on the list
									ent_we      = 1'b1;
									ent_wdata   = '0;
									lnk_we      = 1'b1;
									lnk_wdata   = free_head_q;
									free_head_d = slot;
								end
								CMD_SET_CONTENT: begin
									if (content_bad) begin
										rsp_d.status = STS_BAD_CONTENT;
									end else begin
										ent_we                 = 1'b1;
										ent_wdata.content_file = req_s1.content_file[7:0];
										ent_wdata.data_id      = req_s1.content_data_id;
										ent_wdata.cid_len      = req_s1.content_data_len;
									end
								end
								default: begin
									rsp_d.out_content_file     = entry_rd_q.content_file;
									rsp_d.out_content_data_id  = entry_rd_q.data_id;
									rsp_d.out_content_data_len = entry_rd_q.cid_len;
								end
							endcase
						end
					end
					default: begin
						// unknown command: no change, status ok
					end
				endcase
				rsp_d.used_count = hw_d;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// every taken command produces a result with done high
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("taken command produced no result");

	// a result only follows an execute cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result without execute cycle");

	// the list head never points past the slots handed out
	assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= hw_q)
		else $error("free list head beyond high-water count");

	// the high-water count never shrinks
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hw_q >= $past(hw_q))
		else $error("high-water count decreased");

	// a memory write only happens while a command is in execution
	assert property (@(posedge clk) disable iff (!arst_n)
		(ent_we || lnk_we) |-> (state_q == ST_EXEC))
		else $error("memory write outside execute cycle");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the key slot table: random and directed commands go
// through the start/busy handshake, a local table model predicts every result,
// and the monitor compares each done strobe with the oldest prediction.
module tb;
	import ksa_pkg::*;

	// spare command codes the block must treat as no-ops
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam int KEY_POOL    = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int RAND_PHASES = 13;
	localparam int PHASE_ITEMS = 100;

	localparam logic [63:0] ONES_HI = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [39:0] ONES_LO = 40'hFF_FFFF_FFFF;

	// one entry of the stimulus backlog: a command or a file id write
	typedef struct {
		bit         is_cfg;
		logic [7:0] file_id;
		ksa_in_t    item;
	} backlog_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	ksa_in_t    req       = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;
	logic       done;
	ksa_out_t   rsp;

	key_slot_table_allocator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

	// table model state: entries, free-list links, high-water mark, list head
	bit [63:0]       key_hi_mem   [SLOTS];
	bit [39:0]       key_lo_mem   [SLOTS];
	bit [7:0]        cid_file_mem [SLOTS];
	bit [31:0]       cid_data_mem [SLOTS];
	bit [31:0]       cid_len_mem  [SLOTS];
	bit [SLOT_W-1:0] link_mem     [SLOTS];
	bit [SLOT_W-1:0] hw_count;
	bit [SLOT_W-1:0] free_top;
	bit [7:0]        cur_file;

	backlog_t cmd_backlog [$];
	ksa_out_t rsp_due [$];

	logic [63:0] pool_hi [KEY_POOL];
	logic [39:0] pool_lo [KEY_POOL];

	// driver scratch
	backlog_t   head;
	logic       nx_start;
	ksa_in_t    nx_req;
	logic       nx_cfg_valid;
	logic [7:0] nx_cfg_data;
	int         gap_left;
	int         quiet_cycles;
	int         transfers;
	bit         burst;
	bit         no_gaps;

	// monitor and bookkeeping
	ksa_out_t want;
	int       mismatches;
	int       stall_cycles;
	int       cfg_count;
	int       hit_count;
	int       cmd_count    [8];
	int       status_count [8];

	// generator scratch
	ksa_in_t    c;
	logic [7:0] fid;
	int         est_top;
	int         k;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the table model by one command and return the result it must give.
	function automatic ksa_out_t table_step(input ksa_in_t t);
		ksa_out_t        r;
		bit [SLOT_W-1:0] slot;
		bit              id_ok;
		r = '0;
		id_ok = (t.block_file == cur_file) && (t.block_index != 0)
			&& (t.block_index < SLOTS) && (t.block_index <= hw_count);
		slot = t.block_index[SLOT_W-1:0];
		if (t.cmd == CMD_WRITE) begin
			if (t.key_len != KEY_LEN_FULL) begin
				r.status = STS_BAD_KEY;
			end else begin
				slot = '0;
				if (free_top != 0 && free_top <= hw_count) begin
					slot = free_top;
					free_top = link_mem[slot];
					link_mem[slot] = '0;
					if (free_top > hw_count) free_top = '0;
				end else if (hw_count < SLOTS - 1) begin
					hw_count++;
					slot = hw_count;
				end
				if (slot == 0) begin
					r.status = STS_FULL;
				end else begin
					key_hi_mem[slot] = t.key_suffix_hi;
					key_lo_mem[slot] = t.key_suffix_lo;
					r.out_file = cur_file;
					r.out_index = slot;
				end
			end
		end else if (t.cmd <= CMD_GET_CONTENT) begin
			if (!id_ok) begin
				r.status = STS_BAD_BLOCK;
			end else begin
				case (t.cmd)
					CMD_COMPARE: begin
						r.matched = (key_hi_mem[slot] == t.key_suffix_hi)
							&& (key_lo_mem[slot] == t.key_suffix_lo);
					end
					CMD_GET: begin
						r.suffix_hi = key_hi_mem[slot];
						r.suffix_lo = key_lo_mem[slot];
					end
					CMD_DELETE: begin
						key_hi_mem[slot] = '0;
						key_lo_mem[slot] = '0;
						cid_file_mem[slot] = '0;
						cid_data_mem[slot] = '0;
						cid_len_mem[slot] = '0;
						link_mem[slot] = free_top;
						free_top = slot;
					end
					CMD_SET_CONTENT: begin
						if (t.content_file > 16'hFF || t.content_data_id == 0
								|| t.content_data_len == 0) begin
							r.status = STS_BAD_CONTENT;
						end else begin
							cid_file_mem[slot] = t.content_file[7:0];
							cid_data_mem[slot] = t.content_data_id;
							cid_len_mem[slot] = t.content_data_len;
						end
					end
					default: begin
						r.out_content_file = cid_file_mem[slot];
						r.out_content_data_id = cid_data_mem[slot];
						r.out_content_data_len = cid_len_mem[slot];
					end
				endcase
			end
		end
		r.used_count = hw_count;
		return r;
	endfunction

	// Draw the idle gap before the next transfer; every 50 transfers decide
	// whether the following stretch runs back to back.
	function automatic int draw_gap();
		transfers++;
		if (transfers % 50 == 0) burst = ($urandom_range(0, 2) == 0);
		if (no_gaps || burst) return 0;
		return $urandom_range(0, 13);
	endfunction

	// Random command aimed mostly at allocated slots of the current file.
	function automatic ksa_in_t rand_item(input logic [7:0] f, input int top);
		ksa_in_t t;
		int      sel;
		sel = $urandom_range(0, 99);
		if (sel < 32) t.cmd = CMD_WRITE;
		else if (sel < 44) t.cmd = CMD_COMPARE;
		else if (sel < 56) t.cmd = CMD_GET;
		else if (sel < 66) t.cmd = CMD_DELETE;
		else if (sel < 80) t.cmd = CMD_SET_CONTENT;
		else if (sel < 97) t.cmd = CMD_GET_CONTENT;
		else t.cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
		t.block_file = ($urandom_range(0, 9) != 0) ? f : 8'($urandom);
		sel = $urandom_range(0, 19);
		if (sel < 17) t.block_index = (top == 0) ? 32'd1 : 32'($urandom_range(1, top));
		else if (sel < 19) t.block_index = 32'($urandom_range(0, SLOTS));
		else t.block_index = $urandom;
		t.key_len = (t.cmd != CMD_WRITE || $urandom_range(0, 7) == 0) ? 5'($urandom)
			: KEY_LEN_FULL;
		// reuse pooled keys so compares hit often
		if ($urandom_range(0, 4) < 3) begin
			sel = $urandom_range(0, KEY_POOL - 1);
			t.key_suffix_hi = pool_hi[sel];
			t.key_suffix_lo = pool_lo[sel];
		end else begin
			t.key_suffix_hi = {$urandom, $urandom};
			t.key_suffix_lo = {8'($urandom), $urandom};
		end
		t.content_file = 16'($urandom);
		t.content_data_id = $urandom;
		t.content_data_len = $urandom;
		sel = $urandom_range(0, 9);
		if (sel < 8) begin
			t.content_file = 16'($urandom_range(0, 255));
			if (t.content_data_id == 0) t.content_data_id = 32'd1;
			if (t.content_data_len == 0) t.content_data_len = 32'd1;
		end else if (sel == 8) begin
			if ($urandom_range(0, 1)) t.content_data_id = '0;
			else t.content_data_len = '0;
		end
		return t;
	endfunction

	task automatic add_item(input ksa_in_t t);
		backlog_t e;
		e.is_cfg = 1'b0;
		e.file_id = '0;
		e.item = t;
		cmd_backlog.push_back(e);
	endtask

	task automatic add_cmd(input logic [2:0] op, input logic [7:0] f, input logic [31:0] idx,
			input logic [4:0] klen, input logic [63:0] khi, input logic [39:0] klo,
			input logic [15:0] cf, input logic [31:0] cid, input logic [31:0] clen);
		ksa_in_t t;
		t.cmd = op;
		t.block_file = f;
		t.block_index = idx;
		t.key_len = klen;
		t.key_suffix_hi = khi;
		t.key_suffix_lo = klo;
		t.content_file = cf;
		t.content_data_id = cid;
		t.content_data_len = clen;
		add_item(t);
	endtask

	task automatic add_file_id(input logic [7:0] v);
		backlog_t e;
		e.is_cfg = 1'b1;
		e.file_id = v;
		e.item = '0;
		cmd_backlog.push_back(e);
	endtask

	// Hold until every queued transfer has gone out and every result is back.
	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || start || cfg_valid || rsp_due.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Driver: one transfer at a time on either the command or the file id port.
	// The next values are worked out in temporaries so each output gets exactly
	// one nonblocking assignment per edge, even when start stays high across items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			gap_left = 0;
			quiet_cycles = 0;
		end else begin
			nx_start = start;
			nx_req = req;
			nx_cfg_valid = cfg_valid;
			nx_cfg_data = cfg_data;
			// count cycles with nothing in flight; a file id write waits on this
			if (!start && !cfg_valid && rsp_due.size() == 0) quiet_cycles++;
			else quiet_cycles = 0;
			if (start && !busy) begin
				cmd_count[req.cmd]++;
				rsp_due.push_back(table_step(req));
				nx_start = 1'b0;
				gap_left = draw_gap();
			end
			if (cfg_valid && cfg_ready) begin
				cur_file = cfg_data;
				cfg_count++;
				nx_cfg_valid = 1'b0;
				gap_left = draw_gap();
			end
			if (!nx_start && !nx_cfg_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (cmd_backlog.size() != 0) begin
					if (!cmd_backlog[0].is_cfg) begin
						head = cmd_backlog.pop_front();
						nx_start = 1'b1;
						nx_req = head.item;
					end else if (quiet_cycles >= 4) begin
						// the block is idle, with no result outstanding
						head = cmd_backlog.pop_front();
						nx_cfg_valid = 1'b1;
						nx_cfg_data = head.file_id;
					end
				end
			end
			start <= nx_start;
			req <= nx_req;
			cfg_valid <= nx_cfg_valid;
			cfg_data <= nx_cfg_data;
		end
	end

	// Monitor: a result lives for one cycle only, so take it on every done.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $time, rsp);
			end else begin
				want = rsp_due.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("matched", want.matched, rsp.matched);
				check_field("out_file", want.out_file, rsp.out_file);
				check_field("out_index", want.out_index, rsp.out_index);
				check_field("suffix_hi", want.suffix_hi, rsp.suffix_hi);
				check_field("suffix_lo", want.suffix_lo, rsp.suffix_lo);
				check_field("out_content_file", want.out_content_file, rsp.out_content_file);
				check_field("out_content_data_id", want.out_content_data_id,
					rsp.out_content_data_id);
				check_field("out_content_data_len", want.out_content_data_len,
					rsp.out_content_data_len);
				check_field("used_count", want.used_count, rsp.used_count);
				status_count[want.status]++;
				if (want.matched) hit_count++;
			end
		end
	end

	// Watchdog: end the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready) || done) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		no_gaps = 1'b0;
		pool_hi[0] = ONES_HI;
		pool_lo[0] = ONES_LO;
		pool_hi[1] = '0;
		pool_lo[1] = '0;
		for (k = 2; k < KEY_POOL; k++) begin
			pool_hi[k] = {$urandom, $urandom};
			pool_lo[k] = {8'($urandom), $urandom};
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, file id still at its reset value of zero
		add_cmd(CMD_GET, 8'h00, 32'd1, KEY_LEN_FULL, '0, '0, '0, '0, '0); // empty table
		add_cmd(CMD_WRITE, 8'h00, '0, 5'd15, ONES_HI, ONES_LO, '0, '0, '0); // short key
		add_cmd(CMD_WRITE, 8'h00, '0, KEY_LEN_FULL, ONES_HI, ONES_LO, '0, '0, '0);
		add_cmd(CMD_WRITE, 8'h00, '0, KEY_LEN_FULL, '0, '0, '0, '0, '0);
		add_cmd(CMD_COMPARE, 8'h00, 32'd1, '0, ONES_HI, ONES_LO, '0, '0, '0);
		add_cmd(CMD_COMPARE, 8'h00, 32'd1, '0, ONES_HI, '0, '0, '0, '0);
		add_cmd(CMD_GET, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		// block id rejects: index zero, past high water, foreign file, huge index
		add_cmd(CMD_GET, 8'h00, 32'd0, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET, 8'h00, 32'd3, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET, 8'hFF, 32'd1, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_DELETE, 8'h00, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_SET_CONTENT, 8'h00, 32'd1, '0, '0, '0, 16'h00FF, '1, '1);
		add_cmd(CMD_GET_CONTENT, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		// content id rejects: wide file, zero id, zero length
		add_cmd(CMD_SET_CONTENT, 8'h00, 32'd1, '0, '0, '0, 16'h0100, 32'd1, 32'd1);
		add_cmd(CMD_SET_CONTENT, 8'h00, 32'd1, '0, '0, '0, 16'h0001, 32'd0, 32'd1);
		add_cmd(CMD_SET_CONTENT, 8'h00, 32'd1, '0, '0, '0, 16'h0001, 32'd1, 32'd0);
		// double delete puts slot 1 on the free list twice
		add_cmd(CMD_DELETE, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_DELETE, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET_CONTENT, 8'h00, 32'd1, '0, '0, '0, '0, '0, '0);
		// two pops of slot 1, then a fresh slot
		add_cmd(CMD_WRITE, 8'h00, '0, KEY_LEN_FULL, 64'h0123_4567_89AB_CDEF, 40'h1, '0, '0, '0);
		add_cmd(CMD_WRITE, 8'h00, '0, KEY_LEN_FULL, 64'h1, 40'h12_3456_789A, '0, '0, '0);
		add_cmd(CMD_WRITE, 8'h00, '0, KEY_LEN_FULL, ONES_HI, '0, '0, '0, '0);
		add_cmd(CMD_SPARE_6, 8'hFF, '1, '1, ONES_HI, ONES_LO, '1, '1, '1);
		add_cmd(CMD_SPARE_7, 8'h00, 32'd1, KEY_LEN_FULL, '0, '0, '0, '0, '0);

		// random phases, each under its own file id
		for (k = 0; k < RAND_PHASES; k++) begin
			wait_drained();
			case (k % 4)
				0: fid = 8'hFF;
				1: fid = 8'h00;
				default: fid = 8'($urandom_range(1, 254));
			endcase
			add_file_id(fid);
			est_top = hw_count;
			repeat (PHASE_ITEMS) begin
				c = rand_item(fid, est_top);
				if (c.cmd == CMD_WRITE && c.key_len == KEY_LEN_FULL && est_top < SLOTS - 1)
					est_top++;
				add_item(c);
			end
		end

		// last stretch runs back to back under a fresh file id
		wait_drained();
		fid = 8'($urandom);
		add_file_id(fid);
		no_gaps = 1'b1;

		// the topmost slot handed out: free it, take it back, then probe past the top
		add_cmd(CMD_DELETE, fid, 32'(hw_count), '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_WRITE, fid, '0, KEY_LEN_FULL, ONES_HI, ONES_LO, '0, '0, '0);
		add_cmd(CMD_WRITE, fid, '0, KEY_LEN_FULL, '0, ONES_LO, '0, '0, '0);
		add_cmd(CMD_GET, fid, 32'(hw_count), '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET, fid, 32'(hw_count) + 32'd2, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET, fid, SLOTS, '0, '0, '0, '0, '0, '0);
		add_cmd(CMD_GET_CONTENT, fid, 32'(hw_count), '0, '0, '0, '0, '0, '0);
		repeat (PHASE_ITEMS) add_item(rand_item(fid, int'(hw_count) + 1));

		// drain, then allow a few cycles for any stray result
		wait_drained();
		repeat (6) @(negedge clk);
		if (rsp_due.size() != 0) begin
			mismatches += rsp_due.size();
			$display("%0t: %0d results never arrived", $time, rsp_due.size());
		end

		$display("Ran %0d commands (write %0d, compare %0d, get %0d, delete %0d, set %0d, "
			, cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3] + cmd_count[4]
			+ cmd_count[5] + cmd_count[6] + cmd_count[7], cmd_count[0], cmd_count[1],
			cmd_count[2], cmd_count[3], cmd_count[4],
			"get content %0d, spare %0d) and %0d file id writes, table filled to %0d",
			cmd_count[5], cmd_count[6] + cmd_count[7], cfg_count, hw_count);
		$display("Results: ok %0d, bad key %0d, full %0d, bad block %0d, bad content %0d, hits %0d",
			status_count[STS_OK], status_count[STS_BAD_KEY], status_count[STS_FULL],
			status_count[STS_BAD_BLOCK], status_count[STS_BAD_CONTENT], hit_count);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
